@@ rtl/spq_pkg.sv @@
// Package for the sorted priority queue: sizes, entry type, codes and helpers.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int DEPTH         = 8;
  localparam int PAYLOAD_BYTES = 5;

  localparam int PAY_IN_W = 40;
  localparam int PAY_W    = 8 * PAYLOAD_BYTES;
  localparam int PRIO_W   = 8;
  localparam int ARR_W    = 16;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = $clog2(DEPTH + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [PAY_W-1:0]  payload;
    logic [PRIO_W-1:0] prio;
    logic [ARR_W-1:0]  arr;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctrl_t;

  function automatic logic [PAY_IN_W-1:0] widen_payload(input logic [PAY_W-1:0] p);
    logic [PAY_IN_W-1:0] w;
    w = '0;
    w[PAY_W-1:0] = p;
    return w;
  endfunction

endpackage

@@ rtl/spq_if.sv @@
// Request and response channel interfaces of the sorted priority queue.
`timescale 1ns / 1ps
interface spq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [spq_pkg::PAY_IN_W-1:0]  payload;
  logic [spq_pkg::PRIO_W-1:0]    priority_req;
  logic [spq_pkg::ARR_W-1:0]     arrival;

  modport source (output valid, op, payload, priority_req, arrival, input ready);
  modport sink (input valid, op, payload, priority_req, arrival, output ready);
endinterface

interface spq_out_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::STAT_W-1:0]    status;
  logic [spq_pkg::PAY_IN_W-1:0]  out_payload;
  logic [spq_pkg::PRIO_W-1:0]    out_priority;
  logic [spq_pkg::ARR_W-1:0]     out_arrival;

  modport source (output valid, status, out_payload, out_priority, out_arrival, input ready);
  modport sink (input valid, status, out_payload, out_priority, out_arrival, output ready);
endinterface

@@ rtl/spq_cell.sv @@
// One cell of the sorted row: holds one entry, shifts up on insert, down on remove.
`timescale 1ns / 1ps
module spq_cell (
  input  logic                clk,
  input  spq_pkg::spq_ctrl_t  ctrl,
  input  logic                valid,
  input  logic                prev_go,
  input  spq_pkg::entry_t     prev_entry,
  input  spq_pkg::entry_t     next_entry,
  input  spq_pkg::entry_t     new_entry,
  output logic                go,
  output spq_pkg::entry_t     entry
);
  import spq_pkg::*;

  entry_t entry_next;

  // new entry lands in front of this cell's content
  assign go = !valid || ({entry.prio, entry.arr} > {new_entry.prio, new_entry.arr});

  always_comb begin
    entry_next = entry;
    if (ctrl.ins && go) begin
      entry_next = prev_go ? prev_entry : new_entry;
    end else if (ctrl.rem) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ rtl/sorted_priority_queue_top.sv @@
// Top level of the sorted priority queue: cell row, occupancy and response register.
`timescale 1ns / 1ps
// Bounded priority queue of DEPTH entries kept sorted in a row of cells, lowest priority
// value first and equal priorities by arrival, first in first out on full ties. Every
// request transaction (insert or remove) yields one response transaction in the next cycle;
// a new request is taken each cycle, held back only while a response waits unread.
// Inserts into a full queue are answered with status full and change nothing; removes
// from an empty queue return status empty with zero fields. Payload bits above
// PAYLOAD_BYTES bytes are dropped on insert.
module sorted_priority_queue_top (
  input  logic        clk,
  input  logic        rst,
  spq_in_if.sink      req,
  spq_out_if.source   rsp
);
  import spq_pkg::*;

  logic [OCC_W-1:0] occupancy;
  logic [OCC_W-1:0] occupancy_next;
  logic             take;
  logic             is_full;
  logic             is_empty;
  spq_ctrl_t        ctrl;
  entry_t           new_entry;
  entry_t           cells [DEPTH];
  logic             go [DEPTH];

  assign req.ready = !rsp.valid || rsp.ready;
  assign take      = req.valid && req.ready;
  assign is_full   = (occupancy == OCC_W'(DEPTH));
  assign is_empty  = (occupancy == '0);

  assign ctrl.ins = take && (req.op == OP_INSERT) && !is_full;
  assign ctrl.rem = take && (req.op == OP_REMOVE) && !is_empty;

  assign new_entry.payload = req.payload[PAY_W-1:0];
  assign new_entry.prio    = req.priority_req;
  assign new_entry.arr     = req.arrival;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (OCC_W'(i) < occupancy),
      .prev_go    ((i == 0) ? 1'b0 : go[(i == 0) ? 0 : i - 1]),
      .prev_entry (cells[(i == 0) ? 0 : i - 1]),
      .next_entry (cells[(i == DEPTH - 1) ? i : i + 1]),
      .new_entry  (new_entry),
      .go         (go[i]),
      .entry      (cells[i])
    );
  end

  always_comb begin
    occupancy_next = occupancy;
    if (ctrl.ins) begin
      occupancy_next = occupancy + OCC_W'(1);
    end else if (ctrl.rem) begin
      occupancy_next = occupancy - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      rsp.valid <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      if (take) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.status       <= ST_OK;
      rsp.out_payload  <= '0;
      rsp.out_priority <= '0;
      rsp.out_arrival  <= '0;
      if (req.op == OP_INSERT) begin
        if (is_full) begin
          rsp.status <= ST_FULL;
        end
      end else if (is_empty) begin
        rsp.status <= ST_EMPTY;
      end else begin
        rsp.out_payload  <= widen_payload(cells[0].payload);
        rsp.out_priority <= cells[0].prio;
        rsp.out_arrival  <= cells[0].arr;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (occupancy >= OCC_W'(2)) |-> ({cells[0].prio, cells[0].arr} <= {cells[1].prio, cells[1].arr}))
    else $error("head cell out of order");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (take && req.op == OP_REMOVE && !is_empty) |=> (occupancy == $past(occupancy) - OCC_W'(1)))
    else $error("remove did not shrink queue");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (take && req.op == OP_INSERT && is_full) |=> (rsp.valid && rsp.status == ST_FULL && is_full))
    else $error("full insert not rejected");
`endif

endmodule

@@ tb/spq_checker.sv @@
// Checker for the sorted priority queue: cell row model, response queue and field compare.
`timescale 1ns / 1ps
module spq_checker (
  input  logic clk,
  input  logic rst,
  spq_in_if    req,
  spq_out_if   rsp,
  output int   errors,
  output int   queued
);
  import spq_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [PAY_IN_W-1:0] payload;
    logic [PRIO_W-1:0]   prio;
    logic [ARR_W-1:0]    arr;
  } response_t;

  entry_t    cell_row [DEPTH];
  int        fill;
  int        fail_count;
  int        queued_count;
  response_t pending_responses [$];

  assign errors = fail_count;
  assign queued = queued_count;

  initial begin
    fail_count   = 0;
    queued_count = 0;
    fill         = 0;
  end

  function automatic response_t serve_request(input logic                op,
                                              input logic [PAY_IN_W-1:0] payload,
                                              input logic [PRIO_W-1:0]   prio,
                                              input logic [ARR_W-1:0]    arr);
    response_t r;
    entry_t    e;
    int        pos;
    r = '0;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        e.payload = payload[PAY_W-1:0];
        e.prio    = prio;
        e.arr     = arr;
        pos = 0;
        // full ties go behind the entries already held
        while (pos < fill && {cell_row[pos].prio, cell_row[pos].arr} <= {prio, arr})
          pos++;
        for (int i = fill; i > pos; i--)
          cell_row[i] = cell_row[i-1];
        cell_row[pos] = e;
        fill++;
      end
    end else if (fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.payload[PAY_W-1:0] = cell_row[0].payload;
      r.prio = cell_row[0].prio;
      r.arr  = cell_row[0].arr;
      for (int i = 1; i < fill; i++)
        cell_row[i-1] = cell_row[i];
      fill--;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %0h, expected %0h", $time, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      fill = 0;
      pending_responses.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_responses.size() == 0) begin
          report_mismatch("unexpected response transaction", 64'(rsp.status), '0);
        end else begin
          want = pending_responses.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.out_payload !== want.payload)
            report_mismatch("out_payload", 64'(rsp.out_payload), 64'(want.payload));
          if (rsp.out_priority !== want.prio)
            report_mismatch("out_priority", 64'(rsp.out_priority), 64'(want.prio));
          if (rsp.out_arrival !== want.arr)
            report_mismatch("out_arrival", 64'(rsp.out_arrival), 64'(want.arr));
        end
      end
      if (req.valid && req.ready)
        pending_responses.push_back(serve_request(req.op, req.payload,
                                                  req.priority_req, req.arrival));
    end
    queued_count <= pending_responses.size();
  end

endmodule

@@ tb/tb_sorted_priority_queue_top.sv @@
// Testbench top for the sorted priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  logic clk;
  logic rst;
  int   errors;
  int   queued;
  bit   tx_steady;
  bit   rx_steady;

  spq_in_if  req ();
  spq_out_if rsp ();

  sorted_priority_queue_top uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  spq_checker queue_check (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .errors (errors),
    .queued (queued)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("sorted_priority_queue_top: mismatch");
    $finish;
  end

  task automatic send(input logic                op,
                      input logic [PAY_IN_W-1:0] pay,
                      input logic [PRIO_W-1:0]   prio,
                      input logic [ARR_W-1:0]    arr);
    int gap;
    gap = tx_steady ? 0 : int'($urandom_range(14, 0));
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.op           <= op;
    req.payload      <= pay;
    req.priority_req <= prio;
    req.arrival      <= arr;
    do @(posedge clk); while (!req.ready);
  endtask

  // response side
  initial begin
    int stall;
    int count;
    count = 0;
    rx_steady = 1'b0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (count % 40 == 0)
        rx_steady = ($urandom_range(3, 0) == 0);
      count++;
      stall = rx_steady ? 0 : int'($urandom_range(14, 0));
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  initial begin
    int                  insert_pct;
    bit                  narrow;
    logic                op;
    logic [PAY_IN_W-1:0] pay;
    logic [PRIO_W-1:0]   prio;
    logic [ARR_W-1:0]    arr;

    tx_steady         = 1'b0;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.op           <= OP_INSERT;
    req.payload      <= '0;
    req.priority_req <= '0;
    req.arrival      <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send(OP_REMOVE, '0, '0, '0);
    send(OP_INSERT, '1, 8'hFF, 16'hFFFF);
    send(OP_INSERT, '0, 8'h00, 16'h0000);
    send(OP_INSERT, 40'hAA_AAAA_AAAA, 8'h80, 16'h1234);
    send(OP_INSERT, 40'h55_5555_5555, 8'h80, 16'h1234);
    send(OP_INSERT, 40'h12_3456_789A, 8'h80, 16'h1233);
    send(OP_INSERT, 40'h0F_0F0F_0F0F, 8'h7F, 16'hFFFF);
    send(OP_INSERT, 40'hF0_F0F0_F0F0, 8'h81, 16'h0000);
    send(OP_INSERT, 40'h80_0000_0001, 8'h00, 16'h0000);
    send(OP_INSERT, 40'h01_0000_0080, 8'h00, 16'h0000);
    send(OP_INSERT, '1, 8'hFF, 16'hFFFF);
    repeat (9) send(OP_REMOVE, '1, 8'hFF, 16'hFFFF);

    for (int blk = 0; blk < 26; blk++) begin
      case ($urandom_range(4, 0))
        0:       insert_pct = 10;
        1:       insert_pct = 35;
        2:       insert_pct = 50;
        3:       insert_pct = 65;
        default: insert_pct = 90;
      endcase
      tx_steady = ($urandom_range(3, 0) == 0);
      narrow    = ($urandom_range(1, 0) != 0);
      for (int n = 0; n < 40; n++) begin
        op   = ($urandom_range(99, 0) < insert_pct) ? OP_INSERT : OP_REMOVE;
        pay  = PAY_IN_W'({$urandom, $urandom});
        prio = narrow ? PRIO_W'($urandom_range(3, 0)) : PRIO_W'($urandom_range(255, 0));
        arr  = narrow ? ARR_W'($urandom_range(3, 0)) : ARR_W'($urandom_range(65535, 0));
        send(op, pay, prio, arr);
      end
    end

    req.valid <= 1'b0;
    @(posedge clk);
    while (queued != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("sorted_priority_queue_top: match");
    else
      $display("sorted_priority_queue_top: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
tb/spq_checker.sv
tb/tb_sorted_priority_queue_top.sv
